// File: design/mwf_pkg.sv
package mwf_pkg;

  // field widths fixed by the item format
  localparam int unsigned CoordW      = 6;
  localparam int unsigned WallsW      = 64;
  localparam int unsigned SideDefault = 64;

  typedef logic [CoordW-1:0] coord_t;
  typedef logic [CoordW:0]   coord_sum_t;
  typedef logic [1:0]        dir_t;

  // reset values of the configuration registers
  localparam coord_t StartXReset = 6'd61;
  localparam coord_t StartYReset = 6'd61;
  localparam coord_t GoalXReset  = 6'd1;
  localparam coord_t GoalYReset  = 6'd1;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_STEP    = 2'd1,
    OP_RESTART = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CFG_START_X = 2'd0,
    CFG_START_Y = 2'd1,
    CFG_GOAL_X  = 2'd2,
    CFG_GOAL_Y  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_DOWN  = 2'd2,
    DIR_LEFT  = 2'd3
  } dir_e;

  // input transaction
  typedef struct packed {
    logic [1:0]        op;
    coord_t            row_index;
    logic [WallsW-1:0] row_walls;
  } cmd_t;

  // result transaction
  typedef struct packed {
    coord_t     pos_x;
    coord_t     pos_y;
    logic [1:0] heading;
    logic       found;
  } res_t;

  // microcode fields
  typedef enum logic [1:0] {
    RD_UP   = 2'd0,
    RD_MID  = 2'd1,
    RD_DOWN = 2'd2
  } rd_sel_e;

  typedef enum logic [1:0] {
    CAP_NONE = 2'd0,
    CAP_UP   = 2'd1,
    CAP_MID  = 2'd2
  } cap_e;

  typedef enum logic {
    COND_NEVER = 1'b0,
    COND_GOAL  = 1'b1
  } cond_e;

  typedef logic [2:0] upc_t;

  typedef struct packed {
    logic    mem_we;
    logic    restart;
    rd_sel_e rd_sel;
    cap_e    cap;
    logic    move;
    cond_e   cond;
    upc_t    target;
    logic    last;
  } uc_word_t;

  // program entry points and steps
  localparam upc_t UA_END     = 3'd0;
  localparam upc_t UA_LOAD    = 3'd1;
  localparam upc_t UA_RESTART = 3'd2;
  localparam upc_t UA_STEP0   = 3'd3;
  localparam upc_t UA_STEP1   = 3'd4;
  localparam upc_t UA_STEP2   = 3'd5;
  localparam upc_t UA_STEP3   = 3'd6;

  localparam uc_word_t UC_IDLE = '{
    mem_we:  1'b0,
    restart: 1'b0,
    rd_sel:  RD_MID,
    cap:     CAP_NONE,
    move:    1'b0,
    cond:    COND_NEVER,
    target:  UA_END,
    last:    1'b0
  };

  // control store
  function automatic uc_word_t uc_rom(upc_t addr);
    uc_word_t w;
    w = UC_IDLE;
    unique case (addr)
      UA_END: begin
        w.last = 1'b1;
      end
      UA_LOAD: begin
        w.mem_we = 1'b1;
        w.last   = 1'b1;
      end
      UA_RESTART: begin
        w.restart = 1'b1;
        w.last    = 1'b1;
      end
      UA_STEP0: begin
        w.rd_sel = RD_UP;
        w.cond   = COND_GOAL;
        w.target = UA_END;
      end
      UA_STEP1: begin
        w.cap    = CAP_UP;
        w.rd_sel = RD_MID;
      end
      UA_STEP2: begin
        w.cap    = CAP_MID;
        w.rd_sel = RD_DOWN;
      end
      UA_STEP3: begin
        w.move = 1'b1;
        w.last = 1'b1;
      end
      default: begin
        w.last = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

// File: design/mwf_maze_mem.sv
module mwf_maze_mem #(
  parameter int unsigned Side = mwf_pkg::SideDefault
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [$clog2(Side)-1:0] waddr_i,
  input  logic [Side-1:0]         wdata_i,
  input  logic [$clog2(Side)-1:0] raddr_i,
  output logic [Side-1:0]         rdata_o
);

  logic [Side-1:0] mem_q [Side];
  logic [Side-1:0] rdata_q;

  // one write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // one registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/mwf_sequencer.sv
module mwf_sequencer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [1:0]         op_i,
  input  logic               goal_i,
  output logic               busy_o,
  output logic               done_o,
  output mwf_pkg::uc_word_t  ctrl_o
);

  mwf_pkg::upc_t     upc_q, upc_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  mwf_pkg::uc_word_t word;
  mwf_pkg::upc_t     entry;

  // control word of the current step
  assign word = mwf_pkg::uc_rom(upc_q);

  // entry point for the accepted op
  always_comb begin
    unique case (op_i)
      mwf_pkg::OP_LOAD:    entry = mwf_pkg::UA_LOAD;
      mwf_pkg::OP_STEP:    entry = mwf_pkg::UA_STEP0;
      mwf_pkg::OP_RESTART: entry = mwf_pkg::UA_RESTART;
      default:             entry = mwf_pkg::UA_END;
    endcase
  end

  // step counter with conditional jump
  always_comb begin
    upc_d  = upc_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (busy_q) begin
      if (word.last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else if (word.cond == mwf_pkg::COND_GOAL && goal_i) begin
        upc_d = word.target;
      end else begin
        upc_d = upc_q + 3'd1;
      end
    end else if (start_i) begin
      busy_d = 1'b1;
      upc_d  = entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q  <= mwf_pkg::UA_END;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      upc_q  <= upc_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign ctrl_o = busy_q ? word : mwf_pkg::UC_IDLE;
  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

// File: design/mwf_datapath.sv
module mwf_datapath #(
  parameter int unsigned Side = mwf_pkg::SideDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  mwf_pkg::cmd_t     cmd_i,
  input  mwf_pkg::uc_word_t ctrl_i,
  input  mwf_pkg::coord_t   start_x_i,
  input  mwf_pkg::coord_t   start_y_i,
  input  mwf_pkg::coord_t   goal_x_i,
  input  mwf_pkg::coord_t   goal_y_i,
  output logic              goal_o,
  output mwf_pkg::res_t     res_o
);

  localparam int unsigned AddrW    = $clog2(Side);
  localparam int unsigned TblDepth = 2 ** (mwf_pkg::CoordW + 1);
  localparam mwf_pkg::coord_sum_t OffInc = mwf_pkg::coord_sum_t'(1);
  localparam mwf_pkg::coord_sum_t OffDec = mwf_pkg::coord_sum_t'(Side - 1);
  localparam mwf_pkg::coord_sum_t RowLim = mwf_pkg::coord_sum_t'(Side);

  // captured row write
  mwf_pkg::coord_t   row_index_q;
  logic [Side-1:0]   row_walls_q;

  // walker state
  mwf_pkg::coord_t   x_q, x_d;
  mwf_pkg::coord_t   y_q, y_d;
  mwf_pkg::dir_t     dir_q, dir_d;
  logic              goal_q, goal_d;

  // captured wall bits
  logic              wall_up_q, wall_lf_q, wall_rt_q;

  // wrap table and neighbor coordinates
  mwf_pkg::coord_t   mod_tbl [TblDepth];
  mwf_pkg::coord_t   x_mid, x_lf, x_rt, y_mid, y_up, y_dn;

  logic              mem_we;
  logic [AddrW-1:0]  raddr;
  logic [Side-1:0]   rdata;

  logic [3:0]        walls;
  mwf_pkg::dir_t     d_rt, d1, d1_lf, d2, d2_bk, d3;
  mwf_pkg::coord_t   new_x, new_y;

  // coordinate reduction table built at elaboration
  for (genvar i = 0; i < TblDepth; i++) begin : g_mod
    localparam int unsigned ModVal = i % Side;
    assign mod_tbl[i] = mwf_pkg::coord_t'(ModVal);
  end

  assign x_mid = mod_tbl[{1'b0, x_q}];
  assign y_mid = mod_tbl[{1'b0, y_q}];
  assign x_rt  = mod_tbl[{1'b0, x_q} + OffInc];
  assign x_lf  = mod_tbl[{1'b0, x_q} + OffDec];
  assign y_dn  = mod_tbl[{1'b0, y_q} + OffInc];
  assign y_up  = mod_tbl[{1'b0, y_q} + OffDec];

  // payload capture at acceptance
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      row_index_q <= cmd_i.row_index;
      row_walls_q <= cmd_i.row_walls[Side-1:0];
    end
  end

  // maze row store
  assign mem_we = ctrl_i.mem_we && ({1'b0, row_index_q} < RowLim);

  always_comb begin
    unique case (ctrl_i.rd_sel)
      mwf_pkg::RD_UP:   raddr = y_up[AddrW-1:0];
      mwf_pkg::RD_DOWN: raddr = y_dn[AddrW-1:0];
      default:          raddr = y_mid[AddrW-1:0];
    endcase
  end

  mwf_maze_mem #(
    .Side(Side)
  ) u_maze_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(row_index_q[AddrW-1:0]),
    .wdata_i(row_walls_q),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // wall bit capture from returned rows
  always_ff @(posedge clk_i) begin
    if (ctrl_i.cap == mwf_pkg::CAP_UP) begin
      wall_up_q <= rdata[x_mid[AddrW-1:0]];
    end
    if (ctrl_i.cap == mwf_pkg::CAP_MID) begin
      wall_lf_q <= rdata[x_lf[AddrW-1:0]];
      wall_rt_q <= rdata[x_rt[AddrW-1:0]];
    end
  end

  // right-hand rule, walls indexed by absolute heading
  assign walls = {wall_lf_q, rdata[x_mid[AddrW-1:0]], wall_rt_q, wall_up_q};
  assign d_rt  = dir_q + 2'd1;
  assign d1    = walls[d_rt] ? dir_q : d_rt;
  assign d1_lf = d1 + 2'd3;
  assign d2    = walls[d1_lf] ? d1 : d1_lf;
  assign d2_bk = d2 + 2'd2;
  assign d3    = walls[d1] ? (walls[d2_bk] ? d2 : d2_bk) : d1;

  // next cell for the chosen heading
  always_comb begin
    unique case (mwf_pkg::dir_e'(d3))
      mwf_pkg::DIR_UP: begin
        new_x = x_mid;
        new_y = y_up;
      end
      mwf_pkg::DIR_RIGHT: begin
        new_x = x_rt;
        new_y = y_mid;
      end
      mwf_pkg::DIR_DOWN: begin
        new_x = x_mid;
        new_y = y_dn;
      end
      mwf_pkg::DIR_LEFT: begin
        new_x = x_lf;
        new_y = y_mid;
      end
    endcase
  end

  // walker state update
  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    dir_d  = dir_q;
    goal_d = goal_q;
    if (ctrl_i.restart) begin
      x_d    = start_x_i;
      y_d    = start_y_i;
      dir_d  = mwf_pkg::DIR_UP;
      goal_d = 1'b0;
    end else if (ctrl_i.move) begin
      x_d    = new_x;
      y_d    = new_y;
      dir_d  = d3;
      goal_d = (new_x == goal_x_i) && (new_y == goal_y_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q    <= mwf_pkg::StartXReset;
      y_q    <= mwf_pkg::StartYReset;
      dir_q  <= mwf_pkg::DIR_UP;
      goal_q <= 1'b0;
    end else begin
      x_q    <= x_d;
      y_q    <= y_d;
      dir_q  <= dir_d;
      goal_q <= goal_d;
    end
  end

  assign goal_o        = goal_q;
  assign res_o.pos_x   = x_q;
  assign res_o.pos_y   = y_q;
  assign res_o.heading = dir_q;
  assign res_o.found   = goal_q;

endmodule

// File: design/maze_wall_follower_step.sv
// Right-hand wall follower on a Side x Side grid maze.
// Command channel: drive cmd_i and raise start_i; the transaction is taken at
// a rising edge with start_i high and busy_o low. op 0 writes one maze row,
// op 1 takes one step, op 2 puts the walker back at the start cell facing up.
// Result channel: done_o is high for exactly one cycle and res_o holds the
// walker position, heading and goal flag in that cycle; the receiver must take
// it then, as it cannot hold results off.
// Config channel: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i set
// start and goal cells; ready is always high. Write only while idle.
// Timing: a control store runs one microword per cycle; done_o rises in the
// cycle after the last one. Row load, restart and op 3 run only their entry
// microword, a step once the goal is reached runs UA_STEP0 then UA_END, and a
// walking step runs UA_STEP0 to UA_STEP3, since the maze store has a single
// registered read port and a step reads three rows (above, own, below). A new
// command is taken in the cycle done_o is high.
// Reset: walker at (61, 61) facing up, goal flag clear, start (61, 61) and
// goal (1, 1). Maze rows are undefined until written.
module maze_wall_follower_step #(
  parameter int unsigned Side = mwf_pkg::SideDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  mwf_pkg::cmd_t   cmd_i,
  output logic            done_o,
  output mwf_pkg::res_t   res_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [1:0]      cfg_index_i,
  input  mwf_pkg::coord_t cfg_data_i
);

  logic              accept;
  logic              goal;
  mwf_pkg::uc_word_t ctrl;

  mwf_pkg::coord_t   start_x_q, start_y_q, goal_x_q, goal_y_q;

  assign accept      = start_i && !busy_o;
  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q <= mwf_pkg::StartXReset;
      start_y_q <= mwf_pkg::StartYReset;
      goal_x_q  <= mwf_pkg::GoalXReset;
      goal_y_q  <= mwf_pkg::GoalYReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (mwf_pkg::cfg_idx_e'(cfg_index_i))
        mwf_pkg::CFG_START_X: start_x_q <= cfg_data_i;
        mwf_pkg::CFG_START_Y: start_y_q <= cfg_data_i;
        mwf_pkg::CFG_GOAL_X:  goal_x_q  <= cfg_data_i;
        mwf_pkg::CFG_GOAL_Y:  goal_y_q  <= cfg_data_i;
      endcase
    end
  end

  // microcode sequencer
  mwf_sequencer u_sequencer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .op_i   (cmd_i.op),
    .goal_i (goal),
    .busy_o (busy_o),
    .done_o (done_o),
    .ctrl_o (ctrl)
  );

  // walker datapath and maze store
  mwf_datapath #(
    .Side(Side)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .cmd_i    (cmd_i),
    .ctrl_i   (ctrl),
    .start_x_i(start_x_q),
    .start_y_i(start_y_q),
    .goal_x_i (goal_x_q),
    .goal_y_i (goal_y_q),
    .goal_o   (goal),
    .res_o    (res_o)
  );

  // a result only ends a running program
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o))
    else $error("result strobe without a running program");

  // accepted command starts the program
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o)
    else $error("accepted command did not start the sequencer");

  // one strobe per transaction
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // walker state only changes under microcode
  a_idle_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |=> $stable(res_o))
    else $error("walker state changed while idle");

endmodule

// File: tb/sv/maze_wall_follower_step_checker.sv
module maze_wall_follower_step_checker
  import mwf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  cmd_t        cmd_i,
  input  logic        done_i,
  input  res_t        res_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  coord_t      cfg_data_i,
  output int unsigned errors_o,
  output int unsigned pending_o,
  output int unsigned checked_o,
  output int unsigned goals_o
);

  localparam int unsigned ReportLimit = 10;

  // heading rotations, in quarter turns clockwise
  localparam dir_t TurnRight = 2'd1;
  localparam dir_t TurnBack  = 2'd2;
  localparam dir_t TurnLeft  = 2'd3;

  // own copy of the maze, the walker and the registers
  logic [WallsW-1:0] maze_q [2**CoordW];
  coord_t walker_x, walker_y;
  dir_t   walker_dir;
  logic   at_goal;
  coord_t start_x, start_y, goal_x, goal_y;

  res_t        expected_reports [$];
  res_t        want;
  int unsigned errors, checked, goals;

  // cell one move away, coordinates wrap at the 64-cell grid edge
  function automatic void neighbor(input dir_t d, output coord_t nx, output coord_t ny);
    nx = walker_x;
    ny = walker_y;
    case (dir_e'(d))
      DIR_UP:    ny = walker_y - 1'b1;
      DIR_RIGHT: nx = walker_x + 1'b1;
      DIR_DOWN:  ny = walker_y + 1'b1;
      DIR_LEFT:  nx = walker_x - 1'b1;
      default:   nx = walker_x;
    endcase
  endfunction

  function automatic logic wall_toward(input dir_t d);
    coord_t nx, ny;
    neighbor(d, nx, ny);
    return maze_q[ny][nx];
  endfunction

  // one right-hand-rule step, frozen once the goal is reached
  function automatic void walk_one();
    dir_t   d;
    coord_t nx, ny;
    if (at_goal) return;
    d = walker_dir;
    if (!wall_toward(dir_t'(d + TurnRight))) d = dir_t'(d + TurnRight);
    // blocked ahead: try left, then turn around from wherever that left us
    if (wall_toward(d)) begin
      if (!wall_toward(dir_t'(d + TurnLeft))) d = dir_t'(d + TurnLeft);
      if (!wall_toward(dir_t'(d + TurnBack))) d = dir_t'(d + TurnBack);
    end
    // the move happens even into a wall
    neighbor(d, nx, ny);
    walker_dir = d;
    walker_x   = nx;
    walker_y   = ny;
    if (walker_x == goal_x && walker_y == goal_y) at_goal = 1'b1;
  endfunction

  // apply one command and report the walker state it leaves behind
  function automatic res_t report_after(input cmd_t c);
    res_t r;
    case (c.op)
      OP_LOAD: maze_q[c.row_index] = c.row_walls;
      OP_STEP: walk_one();
      OP_RESTART: begin
        walker_x   = start_x;
        walker_y   = start_y;
        walker_dir = DIR_UP;
        at_goal    = 1'b0;
      end
      default: r = '0;
    endcase
    r.pos_x   = walker_x;
    r.pos_y   = walker_y;
    r.heading = walker_dir;
    r.found   = at_goal;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walker_x   = StartXReset;
      walker_y   = StartYReset;
      walker_dir = DIR_UP;
      at_goal    = 1'b0;
      start_x    = StartXReset;
      start_y    = StartYReset;
      goal_x     = GoalXReset;
      goal_y     = GoalYReset;
      expected_reports.delete();
      errors  = 0;
      checked = 0;
      goals   = 0;
      errors_o  <= 0;
      pending_o <= 0;
      checked_o <= 0;
      goals_o   <= 0;
    end else begin
      // result transaction against the oldest expectation
      if (done_i) begin
        if (expected_reports.size() == 0) begin
          errors++;
          if (errors <= ReportLimit) begin
            $display("unexpected result x=%0d y=%0d dir=%0d found=%0b", res_i.pos_x,
                     res_i.pos_y, res_i.heading, res_i.found);
          end
        end else begin
          want = expected_reports.pop_front();
          checked++;
          if (want.found) goals++;
          if (res_i.pos_x !== want.pos_x || res_i.pos_y !== want.pos_y ||
              res_i.heading !== want.heading || res_i.found !== want.found) begin
            errors++;
            if (errors <= ReportLimit) begin
              $display("result %0d mismatch: expected x=%0d y=%0d dir=%0d found=%0b,",
                       checked, want.pos_x, want.pos_y, want.heading, want.found);
              $display("  got x=%0d y=%0d dir=%0d found=%0b", res_i.pos_x, res_i.pos_y,
                       res_i.heading, res_i.found);
            end
          end
        end
      end
      // register write
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_START_X: start_x = cfg_data_i;
          CFG_START_Y: start_y = cfg_data_i;
          CFG_GOAL_X:  goal_x  = cfg_data_i;
          CFG_GOAL_Y:  goal_y  = cfg_data_i;
          default:     goal_y  = goal_y;
        endcase
      end
      // command transaction
      if (start_i && !busy_i) expected_reports.push_back(report_after(cmd_i));
      errors_o  <= errors;
      pending_o <= expected_reports.size();
      checked_o <= checked;
      goals_o   <= goals;
    end
  end

endmodule

// File: tb/sv/maze_wall_follower_step_test.sv
module maze_wall_follower_step_test;
  import mwf_pkg::*;

  localparam int unsigned CycleLimit      = 300000;
  localparam int unsigned Segments        = 6;
  localparam int unsigned ItemsPerSegment = 325;
  localparam logic [1:0]  OpUnused        = 2'd3;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       start     = 1'b0;
  cmd_t       cmd       = '0;
  logic       cfg_valid = 1'b0;
  logic [1:0] cfg_index = CFG_START_X;
  coord_t     cfg_data  = '0;

  logic busy, done, cfg_ready;
  res_t res;

  int unsigned errors, pending, checked, goals;
  int unsigned cycles     = 0;
  int unsigned idle_pct   = 0;
  int unsigned burst_left = 0;
  int unsigned n_load = 0, n_step = 0, n_restart = 0, n_unused = 0, n_settings = 0;

  maze_wall_follower_step u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .start_i    (start),
    .busy_o     (busy),
    .cmd_i      (cmd),
    .done_o     (done),
    .res_o      (res),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  maze_wall_follower_step_checker u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .start_i    (start),
    .busy_i     (busy),
    .cmd_i      (cmd),
    .done_i     (done),
    .res_i      (res),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .errors_o   (errors),
    .pending_o  (pending),
    .checked_o  (checked),
    .goals_o    (goals)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still expected", cycles, pending);
      $display("status: fail");
      $finish;
    end
  end

  // wall row: open, solid, half, or a sparser random density
  function automatic logic [WallsW-1:0] random_walls();
    logic [WallsW-1:0] w;
    int unsigned       pick, density;
    pick = $urandom_range(99);
    if (pick < 5) begin
      w = '0;
    end else if (pick < 10) begin
      w = '1;
    end else if (pick < 35) begin
      w = {$urandom, $urandom};
    end else begin
      density = $urandom_range(40, 15);
      for (int i = 0; i < WallsW; i++) w[i] = ($urandom_range(99) < density);
    end
    return w;
  endfunction

  function automatic cmd_t make_cmd(input logic [1:0] op, input coord_t row,
                                    input logic [WallsW-1:0] walls);
    cmd_t c;
    c.op        = op;
    c.row_index = row;
    c.row_walls = walls;
    return c;
  endfunction

  // given op with random row fields
  function automatic cmd_t op_cmd(input logic [1:0] op);
    return make_cmd(op, coord_t'($urandom_range(63)), random_walls());
  endfunction

  // mostly steps, with row rewrites, restarts and the odd unused op
  function automatic cmd_t random_cmd();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 58) return op_cmd(OP_STEP);
    else if (pick < 66) return op_cmd(OP_RESTART);
    else if (pick < 95) return op_cmd(OP_LOAD);
    else return op_cmd(OpUnused);
  endfunction

  // one command transaction, with random sender gaps ahead of it
  task automatic issue(input cmd_t c);
    if (burst_left > 0) begin
      burst_left--;
    end else if ($urandom_range(99) < 8) begin
      burst_left = $urandom_range(30, 10);
    end else begin
      while ($urandom_range(99) < idle_pct) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    case (c.op)
      OP_LOAD:    n_load++;
      OP_STEP:    n_step++;
      OP_RESTART: n_restart++;
      default:    n_unused++;
    endcase
  endtask

  // stop sending and wait for every outstanding result
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // write all four registers back to back
  task automatic set_regs(input coord_t sx, input coord_t sy, input coord_t gx,
                          input coord_t gy);
    cfg_idx_e idx [4];
    coord_t   val [4];
    idx = '{CFG_START_X, CFG_START_Y, CFG_GOAL_X, CFG_GOAL_Y};
    val = '{sx, sy, gx, gy};
    foreach (idx[i]) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  initial begin
    coord_t sx, sy;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_pct = 35;

    // fill every row before any step; row 0 open, row 63 solid
    for (int r = 0; r < 64; r++) begin
      issue(make_cmd(OP_LOAD, coord_t'(r), (r == 0) ? '0 : ((r == 63) ? '1 : random_walls())));
    end

    // reset state: unused op, a step from the reset cell, restart at the reset start
    issue(make_cmd(OpUnused, '1, '1));
    issue(op_cmd(OP_STEP));
    issue(op_cmd(OP_RESTART));
    issue(op_cmd(OP_STEP));

    settle();
    set_regs(coord_t'(0), coord_t'(0), coord_t'(0), coord_t'(63));
    // corner start, right walled: move up wraps onto the goal, then holds still
    issue(make_cmd(OP_LOAD, coord_t'(0), ~64'd1));
    issue(make_cmd(OP_LOAD, coord_t'(63), '0));
    issue(op_cmd(OP_RESTART));
    issue(op_cmd(OP_STEP));
    issue(op_cmd(OP_STEP));
    issue(make_cmd(OpUnused, '0, '0));
    issue(op_cmd(OP_RESTART));
    // above walled too: left turn, wrapping to column 63
    issue(make_cmd(OP_LOAD, coord_t'(63), '1));
    issue(make_cmd(OP_LOAD, coord_t'(0), 64'h7FFF_FFFF_FFFF_FFFE));
    issue(op_cmd(OP_STEP));
    // only the cell below open: turn around
    issue(op_cmd(OP_RESTART));
    issue(make_cmd(OP_LOAD, coord_t'(0), '1));
    issue(make_cmd(OP_LOAD, coord_t'(1), '0));
    issue(op_cmd(OP_STEP));
    // boxed in: keeps heading and walks into the wall
    issue(op_cmd(OP_RESTART));
    issue(make_cmd(OP_LOAD, coord_t'(1), '1));
    issue(op_cmd(OP_STEP));

    // random segments: sender gaps 35%, then 45%, then none
    for (int seg = 0; seg < Segments; seg++) begin
      idle_pct = (seg < 2) ? 35 : ((seg < 4) ? 45 : 0);
      settle();
      sx = coord_t'($urandom_range(63));
      sy = coord_t'($urandom_range(63));
      case (seg)
        0: set_regs(coord_t'(63), coord_t'(63), coord_t'(0), coord_t'(0));
        1: set_regs(coord_t'(0), coord_t'(63), coord_t'(63), coord_t'(0));
        5: set_regs(sx, sy, coord_t'($urandom_range(63)), coord_t'($urandom_range(63)));
        // goal a few cells from the start so walks reach it
        default: set_regs(sx, sy, coord_t'(sx + $urandom_range(6) - 3),
                          coord_t'(sy + $urandom_range(6) - 3));
      endcase
      issue(op_cmd(OP_RESTART));
      repeat (ItemsPerSegment) issue(random_cmd());
    end

    settle();
    $display("sent %0d commands: %0d steps, %0d row loads, %0d restarts, %0d unused ops",
             n_load + n_step + n_restart + n_unused, n_step, n_load, n_restart, n_unused);
    $display("%0d results compared over %0d register settings, %0d with the walker on goal",
             checked, n_settings, goals);
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
